### sv/sspk_pkg.sv
package sspk_pkg;

    localparam int MAX_CHARTS_DEF = 64;
    localparam int SIZE_BITS_DEF  = 12;
    localparam int FRAC_BITS      = 20;
    localparam int FRAC_W         = FRAC_BITS + 1;
    localparam int PAD_W          = 4;
    localparam int MIN_SHELF      = 64;
    localparam int RES_W          = 12;
    localparam int INDEX_W        = 6;
    localparam int POS_W          = 19;
    localparam int ATLAS_W        = 20;

    localparam logic [PAD_W-1:0] PAD_RESET = 4'd1;

    // shift unit operand selects
    typedef logic [1:0] frac_sel_t;
    localparam frac_sel_t SEL_SCALE_X = 2'd0;
    localparam frac_sel_t SEL_SCALE_Y = 2'd1;
    localparam frac_sel_t SEL_BIAS_X  = 2'd2;
    localparam frac_sel_t SEL_BIAS_Y  = 2'd3;

endpackage

### sv/shelf_square_chart_packer_top.sv
// Shelf packer for square charts. Charts load one per request, one request per cycle
// while idle (in_ready high). The request marked last starts the packing: for each
// of the n charts a selection scan over the size memory (one memory read port)
// picks the largest unplaced chart (earliest on ties), then states PLA and PLB place
// it on the shelves. State INIT sets up the run and state FIN sizes the atlas. Each
// result then needs a memory read, four passes through the shared shift unit that
// form the U1.20 scale and bias values, and the handshake, which lasts longer while
// out_ready is low. A set of n charts thus holds the input until its last result is
// taken; an empty set answers with one 1x1 result and success low.
module shelf_square_chart_packer_top
    import sspk_pkg::*;
#(
    parameter int MAX_CHARTS = MAX_CHARTS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               padding_we,
    input  logic [PAD_W-1:0]   padding_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               chart_valid,
    input  logic [RES_W-1:0]   resolution,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [INDEX_W-1:0] chart_index,
    output logic [POS_W-1:0]   pos_x,
    output logic [POS_W-1:0]   pos_y,
    output logic [RES_W-1:0]   packed_size,
    output logic [FRAC_W-1:0]  scale_x,
    output logic [FRAC_W-1:0]  scale_y,
    output logic [FRAC_W-1:0]  bias_x,
    output logic [FRAC_W-1:0]  bias_y,
    output logic [ATLAS_W-1:0] atlas_width,
    output logic [ATLAS_W-1:0] atlas_height,
    output logic               success,
    output logic               result_last
);

    localparam int IDX_W = (MAX_CHARTS > 1) ? $clog2(MAX_CHARTS) : 1;
    localparam int CNT_W = $clog2(MAX_CHARTS + 1);
    localparam int SUM_W = SIZE_BITS + IDX_W + 2;
    localparam int SH_W  = $clog2(SUM_W + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_PLA   = 4'd3;
    localparam logic [3:0] ST_PLB   = 4'd4;
    localparam logic [3:0] ST_FIN   = 4'd5;
    localparam logic [3:0] ST_ORD   = 4'd6;
    localparam logic [3:0] ST_OSH   = 4'd7;
    localparam logic [3:0] ST_OSEND = 4'd8;

    function automatic logic [SH_W-1:0] ceil_log2(input logic [SUM_W-1:0] v);
        logic [SH_W-1:0] e;
        e = SH_W'(SUM_W);
        for (int k = SUM_W - 1; k >= 0; k--)
        begin
            if (((SUM_W + 1)'(1) << k) >= (SUM_W + 1)'(v))
            begin
                e = SH_W'(k);
            end
        end
        return e;
    endfunction

    logic [3:0]            state_reg;
    logic [PAD_W-1:0]      pad_reg;
    logic [PAD_W-1:0]      pad_run_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [SUM_W-1:0]      ws_reg;
    logic [SUM_W:0]        shelf_reg;
    logic [SUM_W-1:0]      cx_reg;
    logic [SUM_W-1:0]      cy_reg;
    logic [SIZE_BITS-1:0]  shelf_h_reg;
    logic [SUM_W-1:0]      ext_x_reg;
    logic [SUM_W-1:0]      ext_y_reg;
    logic [MAX_CHARTS-1:0] used_reg;
    logic [CNT_W-1:0]      scan_cnt_reg;
    logic                  s1_vld_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_BITS-1:0]  best_size_reg;
    logic [CNT_W-1:0]      placed_reg;
    logic [SH_W-1:0]       sw_reg;
    logic [SH_W-1:0]       sh_reg;
    logic [CNT_W-1:0]      oi_reg;
    frac_sel_t             k_reg;

    logic                  in_acc;
    logic                  load;
    logic [27:0]           res_ext;
    logic [SIZE_BITS-1:0]  res_cut;
    logic [CNT_W-1:0]      count_next;
    logic [SUM_W-1:0]      half;
    logic [SUM_W-1:0]      shelf_arg;
    logic [SUM_W:0]        fit_end;
    logic [SUM_W:0]        y_end;
    logic [SUM_W-1:0]      cx_adv;
    logic [SH_W-1:0]       ex_log;
    logic [SH_W-1:0]       ey_log;

    logic [IDX_W-1:0]      raddr;
    logic [SIZE_BITS-1:0]  size_rdata;
    logic [SUM_W-1:0]      place_x_rdata;
    logic [SUM_W-1:0]      place_y_rdata;
    logic [SUM_W-1:0]      sh_value;
    logic [SH_W-1:0]       sh_amount;
    logic [FRAC_W-1:0]     sh_frac;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign load     = in_acc && chart_valid && (count_reg < CNT_W'(MAX_CHARTS));
    assign res_ext  = {16'd0, resolution};
    assign res_cut  = res_ext[SIZE_BITS-1:0];
    assign count_next = load ? count_reg + 1'b1 : count_reg;

    assign half      = ws_reg >> 1;
    assign shelf_arg = (half > SUM_W'(MIN_SHELF)) ? half : SUM_W'(MIN_SHELF);
    assign fit_end   = (SUM_W + 1)'(cx_reg) + (SUM_W + 1)'(best_size_reg)
                       + (SUM_W + 1)'(pad_run_reg);
    assign y_end     = (SUM_W + 1)'(cy_reg) + (SUM_W + 1)'(best_size_reg)
                       + (SUM_W + 1)'(pad_run_reg);
    assign cx_adv    = SUM_W'(fit_end);
    assign ex_log    = ceil_log2(ext_x_reg);
    assign ey_log    = ceil_log2(ext_y_reg);

    assign raddr = (state_reg == ST_SCAN) ? scan_cnt_reg[IDX_W-1:0] : oi_reg[IDX_W-1:0];

    sspk_store #(
        .MAX_CHARTS (MAX_CHARTS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W),
        .SUM_W      (SUM_W)
    ) u_store (
        .clk           (clk),
        .size_we       (load),
        .size_waddr    (count_reg[IDX_W-1:0]),
        .size_wdata    (res_cut),
        .place_we      (state_reg == ST_PLB),
        .place_waddr   (best_idx_reg),
        .place_x_wdata (cx_reg),
        .place_y_wdata (cy_reg),
        .raddr         (raddr),
        .size_rdata    (size_rdata),
        .place_x_rdata (place_x_rdata),
        .place_y_rdata (place_y_rdata)
    );

    always_comb
    begin
        case (k_reg)
            SEL_SCALE_X: begin sh_value = SUM_W'(size_rdata); sh_amount = sw_reg; end
            SEL_SCALE_Y: begin sh_value = SUM_W'(size_rdata); sh_amount = sh_reg; end
            SEL_BIAS_X:  begin sh_value = place_x_rdata;      sh_amount = sw_reg; end
            default:     begin sh_value = place_y_rdata;      sh_amount = sh_reg; end
        endcase
    end

    sspk_shift #(
        .SUM_W (SUM_W),
        .SH_W  (SH_W)
    ) u_shift (
        .value  (sh_value),
        .amount (sh_amount),
        .frac   (sh_frac)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pad_reg      <= PAD_RESET;
            count_reg    <= '0;
            ws_reg       <= '0;
            out_valid    <= 1'b0;
            used_reg     <= '0;
            scan_cnt_reg <= '0;
            s1_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            placed_reg   <= '0;
            oi_reg       <= '0;
            k_reg        <= SEL_SCALE_X;
        end
        else
        begin
            if (padding_we)
            begin
                pad_reg <= padding_wdata;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load || (in_acc && last))
                    begin
                        count_reg <= (in_acc && last) ? '0 : count_next;
                    end
                    if (load)
                    begin
                        ws_reg    <= ws_reg + SUM_W'(res_cut) + SUM_W'({pad_reg, 1'b0});
                    end
                    if (in_acc && last)
                    begin
                        n_reg       <= count_next;
                        pad_run_reg <= pad_reg;
                        if (count_next == '0)
                        begin
                            ws_reg       <= '0;
                            chart_index  <= '0;
                            pos_x        <= '0;
                            pos_y        <= '0;
                            packed_size  <= '0;
                            scale_x      <= '0;
                            scale_y      <= '0;
                            bias_x       <= '0;
                            bias_y       <= '0;
                            atlas_width  <= ATLAS_W'(1);
                            atlas_height <= ATLAS_W'(1);
                            success      <= 1'b0;
                            result_last  <= 1'b1;
                            out_valid    <= 1'b1;
                            state_reg    <= ST_OSEND;
                        end
                        else
                        begin
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT:
                begin
                    shelf_reg    <= (SUM_W + 1)'(1) << ceil_log2(shelf_arg);
                    ws_reg       <= '0;
                    cx_reg       <= SUM_W'(pad_run_reg);
                    cy_reg       <= SUM_W'(pad_run_reg);
                    shelf_h_reg  <= '0;
                    ext_x_reg    <= '0;
                    ext_y_reg    <= '0;
                    used_reg     <= '0;
                    placed_reg   <= '0;
                    scan_cnt_reg <= '0;
                    s1_vld_reg   <= 1'b0;
                    found_reg    <= 1'b0;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // read issued this cycle, compared the next
                    s1_vld_reg <= (scan_cnt_reg < n_reg);
                    s1_idx_reg <= scan_cnt_reg[IDX_W-1:0];
                    if (scan_cnt_reg < n_reg)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    if (s1_vld_reg && !used_reg[s1_idx_reg]
                        && (!found_reg || size_rdata > best_size_reg))
                    begin
                        found_reg     <= 1'b1;
                        best_idx_reg  <= s1_idx_reg;
                        best_size_reg <= size_rdata;
                    end
                    if (scan_cnt_reg == n_reg && !s1_vld_reg)
                    begin
                        state_reg <= ST_PLA;
                    end
                end
                ST_PLA:
                begin
                    if (fit_end > shelf_reg)
                    begin
                        cx_reg      <= SUM_W'(pad_run_reg);
                        cy_reg      <= cy_reg + SUM_W'(shelf_h_reg) + SUM_W'(pad_run_reg);
                        shelf_h_reg <= '0;
                    end
                    state_reg <= ST_PLB;
                end
                ST_PLB:
                begin
                    used_reg[best_idx_reg] <= 1'b1;
                    cx_reg <= cx_adv;
                    if (best_size_reg > shelf_h_reg)
                    begin
                        shelf_h_reg <= best_size_reg;
                    end
                    if (cx_adv > ext_x_reg)
                    begin
                        ext_x_reg <= cx_adv;
                    end
                    if (y_end > (SUM_W + 1)'(ext_y_reg))
                    begin
                        ext_y_reg <= SUM_W'(y_end);
                    end
                    placed_reg   <= placed_reg + 1'b1;
                    scan_cnt_reg <= '0;
                    s1_vld_reg   <= 1'b0;
                    found_reg    <= 1'b0;
                    if (placed_reg + 1'b1 == n_reg)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_FIN:
                begin
                    sw_reg       <= ex_log;
                    sh_reg       <= ey_log;
                    atlas_width  <= ATLAS_W'((SUM_W + 1)'(1) << ex_log);
                    atlas_height <= ATLAS_W'((SUM_W + 1)'(1) << ey_log);
                    oi_reg       <= '0;
                    state_reg    <= ST_ORD;
                end
                ST_ORD:
                begin
                    k_reg     <= SEL_SCALE_X;
                    state_reg <= ST_OSH;
                end
                ST_OSH:
                begin
                    case (k_reg)
                        SEL_SCALE_X: scale_x <= sh_frac;
                        SEL_SCALE_Y: scale_y <= sh_frac;
                        SEL_BIAS_X:  bias_x  <= sh_frac;
                        default:     bias_y  <= sh_frac;
                    endcase
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == SEL_BIAS_Y)
                    begin
                        chart_index <= INDEX_W'(oi_reg);
                        pos_x       <= POS_W'(place_x_rdata);
                        pos_y       <= POS_W'(place_y_rdata);
                        packed_size <= RES_W'(size_rdata);
                        success     <= 1'b1;
                        result_last <= (oi_reg + 1'b1 == n_reg);
                        out_valid   <= 1'b1;
                        state_reg   <= ST_OSEND;
                    end
                end
                ST_OSEND:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (result_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            oi_reg    <= oi_reg + 1'b1;
                            state_reg <= ST_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !success |-> result_last && atlas_width == ATLAS_W'(1))
        else $error("empty-set result malformed");

    a_atlas_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(atlas_width) && $onehot(atlas_height))
        else $error("atlas side not a power of two");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && result_last |=> in_ready)
        else $error("block not idle after final result");
`endif

endmodule

### sv/sspk_store.sv
module sspk_store
    import sspk_pkg::*;
#(
    parameter int MAX_CHARTS = MAX_CHARTS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF,
    parameter int IDX_W      = 6,
    parameter int SUM_W      = 20
)
(
    input  logic                 clk,
    input  logic                 size_we,
    input  logic [IDX_W-1:0]     size_waddr,
    input  logic [SIZE_BITS-1:0] size_wdata,
    input  logic                 place_we,
    input  logic [IDX_W-1:0]     place_waddr,
    input  logic [SUM_W-1:0]     place_x_wdata,
    input  logic [SUM_W-1:0]     place_y_wdata,
    input  logic [IDX_W-1:0]     raddr,
    output logic [SIZE_BITS-1:0] size_rdata,
    output logic [SUM_W-1:0]     place_x_rdata,
    output logic [SUM_W-1:0]     place_y_rdata
);

    logic [SIZE_BITS-1:0] size_mem    [MAX_CHARTS];
    logic [SUM_W-1:0]     place_x_mem [MAX_CHARTS];
    logic [SUM_W-1:0]     place_y_mem [MAX_CHARTS];

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        if (place_we)
        begin
            place_x_mem[place_waddr] <= place_x_wdata;
            place_y_mem[place_waddr] <= place_y_wdata;
        end
        size_rdata    <= size_mem[raddr];
        place_x_rdata <= place_x_mem[raddr];
        place_y_rdata <= place_y_mem[raddr];
    end

endmodule

### sv/sspk_shift.sv
module sspk_shift
    import sspk_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int SH_W  = 5
)
(
    input  logic [SUM_W-1:0]  value,
    input  logic [SH_W-1:0]   amount,
    output logic [FRAC_W-1:0] frac
);

    logic [SUM_W+FRAC_BITS-1:0] wide;
    logic [SUM_W+FRAC_BITS-1:0] shifted;

    // value * 2^20 / 2^amount, kept to 21 bits
    assign wide    = {value, {FRAC_BITS{1'b0}}};
    assign shifted = wide >> amount;
    assign frac    = shifted[FRAC_W-1:0];

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import sspk_pkg::*;

    typedef struct {
        logic [INDEX_W-1:0] idx;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [RES_W-1:0]   side;
        logic [FRAC_W-1:0]  sx;
        logic [FRAC_W-1:0]  sy;
        logic [FRAC_W-1:0]  bx;
        logic [FRAC_W-1:0]  by;
        logic [ATLAS_W-1:0] aw;
        logic [ATLAS_W-1:0] ah;
        logic               ok;
        logic               fin;
    } placement_t;

    class chart_atlas_board;
        int unsigned pad = PAD_RESET;
        int unsigned sizes[MAX_CHARTS_DEF];
        int unsigned loaded;
        int unsigned wsum;
        placement_t  pending_placements[$];
        int unsigned errors;
        int unsigned sets;
        int unsigned charts;
        int unsigned results;

        function int unsigned pow2_up(int unsigned v);
            int unsigned p;
            p = 1;
            while (p < v && p < 32'h8000_0000)
                p = p << 1;
            return p;
        endfunction

        function int unsigned exp_of(int unsigned p);
            int unsigned n;
            n = 0;
            while (n < 31 && (p >> n) > 1)
                n++;
            return n;
        endfunction

        function logic [FRAC_W-1:0] ufrac(int unsigned v, int unsigned sh);
            logic [63:0] w;
            w = (64'(v) << FRAC_BITS) >> sh;
            return w[FRAC_W-1:0];
        endfunction

        // accepted request: load chart, and on last run the packing
        function void note_request(bit cv, logic [RES_W-1:0] res, bit lst);
            int unsigned order[MAX_CHARTS_DEF];
            int unsigned px[MAX_CHARTS_DEF];
            int unsigned py[MAX_CHARTS_DEF];
            bit taken[MAX_CHARTS_DEF];
            int unsigned shelf, cx, cy, shh, ex, ey, aw, ah, sw, sh, best, s;
            placement_t r;
            if (cv && loaded < MAX_CHARTS_DEF) begin
                sizes[loaded] = res;
                wsum += res + 2 * pad;
                loaded++;
                charts++;
            end
            if (!lst)
                return;
            sets++;
            if (loaded == 0) begin
                r = '{default: '0};
                r.aw = ATLAS_W'(1);
                r.ah = ATLAS_W'(1);
                r.fin = 1'b1;
                pending_placements.push_back(r);
                wsum = 0;
                return;
            end
            // largest first, earliest load wins ties
            for (int i = 0; i < loaded; i++)
                taken[i] = 1'b0;
            for (int i = 0; i < loaded; i++) begin
                best = loaded;
                for (int k = 0; k < loaded; k++)
                    if (!taken[k] && (best == loaded || sizes[k] > sizes[best]))
                        best = k;
                taken[best] = 1'b1;
                order[i] = best;
            end
            shelf = pow2_up((wsum / 2) > 64 ? wsum / 2 : 64);
            cx = pad;
            cy = pad;
            shh = 0;
            ex = 0;
            ey = 0;
            for (int i = 0; i < loaded; i++) begin
                s = sizes[order[i]];
                if (cx + s + pad > shelf) begin
                    cx = pad;
                    cy += shh + pad;
                    shh = 0;
                end
                px[order[i]] = cx;
                py[order[i]] = cy;
                cx += s + pad;
                if (s > shh)
                    shh = s;
                if (cx > ex)
                    ex = cx;
                if (cy + s + pad > ey)
                    ey = cy + s + pad;
            end
            aw = pow2_up(ex);
            ah = pow2_up(ey);
            sw = exp_of(aw);
            sh = exp_of(ah);
            for (int i = 0; i < loaded; i++) begin
                r.idx = INDEX_W'(i);
                r.px = POS_W'(px[i]);
                r.py = POS_W'(py[i]);
                r.side = RES_W'(sizes[i]);
                r.sx = ufrac(sizes[i], sw);
                r.sy = ufrac(sizes[i], sh);
                r.bx = ufrac(px[i], sw);
                r.by = ufrac(py[i], sh);
                r.aw = ATLAS_W'(aw);
                r.ah = ATLAS_W'(ah);
                r.ok = 1'b1;
                r.fin = (i + 1 == loaded);
                pending_placements.push_back(r);
            end
            loaded = 0;
            wsum = 0;
        endfunction

        function void field_cmp(string nm, longint unsigned e, longint unsigned a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, nm, e, a);
            end
        endfunction

        function void check_result(placement_t a);
            placement_t e;
            results++;
            if (pending_placements.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, index %0d", $time, a.idx);
                return;
            end
            e = pending_placements.pop_front();
            field_cmp("chart_index", e.idx, a.idx);
            field_cmp("pos_x", e.px, a.px);
            field_cmp("pos_y", e.py, a.py);
            field_cmp("packed_size", e.side, a.side);
            field_cmp("scale_x", e.sx, a.sx);
            field_cmp("scale_y", e.sy, a.sy);
            field_cmp("bias_x", e.bx, a.bx);
            field_cmp("bias_y", e.by, a.by);
            field_cmp("atlas_width", e.aw, a.aw);
            field_cmp("atlas_height", e.ah, a.ah);
            field_cmp("success", e.ok, a.ok);
            field_cmp("result_last", e.fin, a.fin);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               padding_we;
    logic [PAD_W-1:0]   padding_wdata;
    logic               in_valid;
    logic               in_ready;
    logic               chart_valid;
    logic [RES_W-1:0]   resolution;
    logic               last;
    logic               out_valid;
    logic               out_ready;
    logic [INDEX_W-1:0] chart_index;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [RES_W-1:0]   packed_size;
    logic [FRAC_W-1:0]  scale_x;
    logic [FRAC_W-1:0]  scale_y;
    logic [FRAC_W-1:0]  bias_x;
    logic [FRAC_W-1:0]  bias_y;
    logic [ATLAS_W-1:0] atlas_width;
    logic [ATLAS_W-1:0] atlas_height;
    logic               success;
    logic               result_last;

    chart_atlas_board board = new();
    bit                 hold_req;
    int unsigned        cycles;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned DRAIN_GAP   = 40;

    shelf_square_chart_packer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .padding_we   (padding_we),
        .padding_wdata(padding_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .chart_valid  (chart_valid),
        .resolution   (resolution),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chart_index  (chart_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .packed_size  (packed_size),
        .scale_x      (scale_x),
        .scale_y      (scale_y),
        .bias_x       (bias_x),
        .bias_y       (bias_y),
        .atlas_width  (atlas_width),
        .atlas_height (atlas_height),
        .success      (success),
        .result_last  (result_last)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(bit cv, logic [RES_W-1:0] res, bit lst);
        int unsigned gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        chart_valid <= cv;
        resolution  <= res;
        last        <= lst;
        do @(posedge clk); while (!in_ready);
        board.note_request(cv, res, lst);
    endtask

    // wait until every pending result is out, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_placements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_padding(logic [PAD_W-1:0] val);
        drain();
        padding_we    <= 1'b1;
        padding_wdata <= val;
        @(posedge clk);
        padding_we    <= 1'b0;
        board.pad = val;
    endtask

    function automatic logic [RES_W-1:0] pick_res();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return RES_W'($urandom_range(0, 255));
            4, 5:       return RES_W'($urandom_range(1, 8) * 16);
            6:          return RES_W'($urandom_range(3968, 4095));
            default:    return RES_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send_set(int unsigned n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_request(1'b0, RES_W'($urandom_range(0, 4095)), 1'b0);
            send_request(1'b1, pick_res(), i + 1 == n);
        end
    endtask

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        int unsigned gap;
        placement_t  got;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (hold_req)
                gap = 3000;
            hold_req = 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.idx  = chart_index;
            got.px   = pos_x;
            got.py   = pos_y;
            got.side = packed_size;
            got.sx   = scale_x;
            got.sy   = scale_y;
            got.bx   = bias_x;
            got.by   = bias_y;
            got.aw   = atlas_width;
            got.ah   = atlas_height;
            got.ok   = success;
            got.fin  = result_last;
            board.check_result(got);
        end
    end

    initial
    begin
        int unsigned sent;
        cycles        = 0;
        hold_req      = 0;
        rst_n         = 1'b0;
        padding_we    = 1'b0;
        padding_wdata = '0;
        in_valid      = 1'b0;
        chart_valid   = 1'b0;
        resolution    = '0;
        last          = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty set, extremes, ties, noise, oversize wrap
        send_request(1'b0, 12'd0, 1'b1);
        send_request(1'b1, 12'd0, 1'b1);
        send_request(1'b1, 12'd4095, 1'b1);
        send_request(1'b1, 12'd5, 1'b0);
        send_request(1'b0, 12'hFFF, 1'b0);
        send_request(1'b1, 12'd5, 1'b0);
        send_request(1'b1, 12'd4095, 1'b0);
        send_request(1'b1, 12'hAAA, 1'b0);
        send_request(1'b1, 12'h555, 1'b0);
        send_request(1'b0, 12'd0, 1'b1);
        write_padding(4'd15);
        send_request(1'b1, 12'd4095, 1'b1);
        send_request(1'b1, 12'd4095, 1'b0);
        send_request(1'b1, 12'd1, 1'b1);
        write_padding(4'd0);
        send_request(1'b1, 12'd0, 1'b0);
        send_request(1'b1, 12'd64, 1'b1);
        // padding change between loads of one set
        send_request(1'b1, 12'd100, 1'b0);
        write_padding(4'd9);
        send_request(1'b1, 12'd300, 1'b0);
        send_request(1'b1, 12'd100, 1'b1);
        drain();

        // overflow: charts past the store limit are dropped
        write_padding(4'd2);
        send_set(MAX_CHARTS_DEF + 3);

        // long receiver hold while the sender keeps offering sets
        hold_req = 1;
        send_set(12);
        send_set(6);
        send_set(5);

        sent = 0;
        while (sent < 220) begin
            case ($urandom_range(0, 9))
                0:       write_padding(PAD_W'($urandom_range(0, 15)));
                1:       write_padding($urandom_range(0, 1) ? 4'd15 : 4'd0);
                2: begin
                    send_request(1'b0, RES_W'($urandom_range(0, 4095)), 1'b1);
                    sent++;
                end
                default: begin
                    int unsigned n;
                    n = $urandom_range(1, 10);
                    send_set(n);
                    sent += n;
                end
            endcase
        end

        drain();
        $display("Covered %0d sets, %0d charts loaded, %0d results checked",
                 board.sets, board.charts, board.results);
        $display("Padding 0 to 15, empty sets, ties, oversize charts and overflow");
        if (board.errors == 0 && board.pending_placements.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
